FILE: hw/rtl/vtlv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtlv_pkg
// Shared types and constants for the varint TLV header parser.
// ----------------------------------------------------------------------------
package vtlv_pkg;

    // Result field widths
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 29;
    localparam int ERR_W   = 2;
    localparam int OUT_CNT_W = 24;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CSIZE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_USIZE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CODEC = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_TRUNC   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_CROSS   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_METHOD  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd3;

    // Record ids
    localparam int ID_W   = 15;
    localparam int LEN_W  = 22;
    localparam logic [ID_W-1:0] ID_END   = 15'd0;
    localparam logic [ID_W-1:0] ID_CSIZE = 15'd1;
    localparam logic [ID_W-1:0] ID_CODEC = 15'd2;
    localparam logic [ID_W-1:0] ID_USIZE = 15'd3;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One result word
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [VALUE_W-1:0]   value;
        logic [ERR_W-1:0]     error_code;
        logic [OUT_CNT_W-1:0] byte_total;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vtlv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtlv_front
// Byte parser: walks records, builds varints and produces one result word
// at most per accepted byte.
// ----------------------------------------------------------------------------
module vtlv_front #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_fire,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    output logic                      res_push,
    output vtlv_pkg::result_t         res_data
);

    localparam int EXT_W = (COUNT_BITS > vtlv_pkg::OUT_CNT_W) ? COUNT_BITS
                                                               : vtlv_pkg::OUT_CNT_W;

    typedef enum logic [2:0] {
        PH_ID  = 3'b001,
        PH_LEN = 3'b010,
        PH_PAY = 3'b100
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [vtlv_pkg::VALUE_W-1:0]    acc_reg, acc_next;
    logic [1:0]                      pos_reg, pos_next;
    logic [vtlv_pkg::ID_W-1:0]       id_reg, id_next;
    logic [vtlv_pkg::LEN_W-1:0]      left_reg, left_next;
    logic [COUNT_BITS-1:0]           cnt_reg, cnt_next;

    logic [COUNT_BITS-1:0]           cnt_inc;
    logic [EXT_W-1:0]                cnt_ext;
    logic [vtlv_pkg::OUT_CNT_W-1:0]  cnt_out;

    // Saturating byte count, this byte included
    assign cnt_inc = (cnt_reg != '1) ? cnt_reg + COUNT_BITS'(1) : cnt_reg;
    assign cnt_ext = EXT_W'(cnt_inc);
    assign cnt_out = (cnt_ext > EXT_W'({vtlv_pkg::OUT_CNT_W{1'b1}}))
                   ? {vtlv_pkg::OUT_CNT_W{1'b1}}
                   : cnt_ext[vtlv_pkg::OUT_CNT_W-1:0];

    // Next state and result for the current byte
    always_comb begin
        logic [vtlv_pkg::LEN_W-1:0]   left_dec;
        logic [vtlv_pkg::VALUE_W-1:0] acc_new;
        logic [vtlv_pkg::ID_W-1:0]    id_val;
        logic                         more;
        logic                         done;
        logic                         do_fail;
        logic                         do_end;
        logic [vtlv_pkg::ERR_W-1:0]   err;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        left_next  = left_reg;
        cnt_next   = cnt_inc;
        left_dec   = '0;
        acc_new    = '0;
        id_val     = '0;
        more       = 1'b0;
        done       = 1'b0;
        do_fail    = 1'b0;
        do_end     = 1'b0;
        err        = vtlv_pkg::ERR_TRUNC;
        res_push   = 1'b0;
        res_data   = '0;

        case (phase_reg)
            PH_PAY: begin
                left_dec  = (left_reg != '0) ? left_reg - vtlv_pkg::LEN_W'(1) : '0;
                left_next = left_dec;
                if (id_reg == vtlv_pkg::ID_CODEC) begin
                    res_data.kind  = vtlv_pkg::KIND_CODEC;
                    res_data.value = vtlv_pkg::VALUE_W'(in_byte);
                    done           = 1'b1;
                end else begin
                    res_data.kind = (id_reg == vtlv_pkg::ID_CSIZE) ? vtlv_pkg::KIND_CSIZE
                                                                   : vtlv_pkg::KIND_USIZE;
                    case (pos_reg)
                        2'd0:    acc_new = acc_reg | vtlv_pkg::VALUE_W'(in_byte[6:0]);
                        2'd1:    acc_new = acc_reg | (vtlv_pkg::VALUE_W'(in_byte[6:0]) << 7);
                        2'd2:    acc_new = acc_reg | (vtlv_pkg::VALUE_W'(in_byte[6:0]) << 14);
                        default: acc_new = acc_reg | (vtlv_pkg::VALUE_W'(in_byte) << 21);
                    endcase
                    more     = (pos_reg != 2'd3) && in_byte[7];
                    acc_next = acc_new;
                    if (more) begin
                        if (left_dec == '0) begin
                            do_fail = 1'b1;
                            err     = vtlv_pkg::ERR_CROSS;
                        end else begin
                            pos_next = pos_reg + 2'd1;
                        end
                    end else begin
                        res_data.value = acc_new;
                        done           = 1'b1;
                        acc_next       = '0;
                        pos_next       = '0;
                    end
                end
                if (left_dec == '0) begin
                    phase_next = PH_ID;
                end
                if (!do_fail) begin
                    if (in_last) begin
                        do_fail = 1'b1;
                        err     = vtlv_pkg::ERR_TRUNC;
                    end else if (done) begin
                        res_push = 1'b1;
                    end
                end
            end
            PH_LEN: begin
                case (pos_reg)
                    2'd0:    acc_new = acc_reg | vtlv_pkg::VALUE_W'(in_byte[6:0]);
                    2'd1:    acc_new = acc_reg | (vtlv_pkg::VALUE_W'(in_byte[6:0]) << 7);
                    default: acc_new = acc_reg | (vtlv_pkg::VALUE_W'(in_byte) << 14);
                endcase
                acc_new = vtlv_pkg::VALUE_W'(acc_new[vtlv_pkg::LEN_W-1:0]);
                more    = (pos_reg == 2'd0 || pos_reg == 2'd1) && in_byte[7];
                if (more) begin
                    acc_next = acc_new;
                    pos_next = pos_reg + 2'd1;
                    if (in_last) begin
                        do_fail = 1'b1;
                    end
                end else begin
                    acc_next = '0;
                    pos_next = '0;
                    if (id_reg == vtlv_pkg::ID_END || id_reg > vtlv_pkg::ID_USIZE) begin
                        do_fail = 1'b1;
                        err     = vtlv_pkg::ERR_UNKNOWN;
                    end else if (id_reg == vtlv_pkg::ID_CODEC &&
                                 acc_new != vtlv_pkg::VALUE_W'(1)) begin
                        do_fail = 1'b1;
                        err     = vtlv_pkg::ERR_METHOD;
                    end else begin
                        if (acc_new == '0) begin
                            phase_next = PH_ID;
                        end else begin
                            phase_next = PH_PAY;
                            left_next  = acc_new[vtlv_pkg::LEN_W-1:0];
                        end
                        if (in_last) begin
                            do_fail = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (pos_reg == 2'd0 && in_byte[7]) begin
                    acc_next   = vtlv_pkg::VALUE_W'(in_byte[6:0]);
                    pos_next   = 2'd1;
                    phase_next = PH_ID;
                    if (in_last) begin
                        do_fail = 1'b1;
                    end
                end else begin
                    id_val   = (pos_reg == 2'd0) ? vtlv_pkg::ID_W'(in_byte[6:0])
                                                 : {in_byte, acc_reg[6:0]};
                    acc_next = '0;
                    pos_next = '0;
                    if (id_val == vtlv_pkg::ID_END) begin
                        do_end              = 1'b1;
                        res_push            = 1'b1;
                        res_data.kind       = vtlv_pkg::KIND_END;
                        res_data.byte_total = cnt_out;
                    end else begin
                        id_next    = id_val;
                        phase_next = PH_LEN;
                        if (in_last) begin
                            do_fail = 1'b1;
                        end
                    end
                end
            end
        endcase

        // Report an error word in place of anything else
        if (do_fail) begin
            res_push            = 1'b1;
            res_data            = '0;
            res_data.kind       = vtlv_pkg::KIND_ERROR;
            res_data.error_code = err;
        end

        // Restart after an end or an error
        if (do_fail || do_end) begin
            phase_next = PH_ID;
            acc_next   = '0;
            pos_next   = '0;
            id_next    = '0;
            left_next  = '0;
            cnt_next   = '0;
        end

        // Nothing moves without a word
        if (!in_fire) begin
            res_push = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ID;
            acc_reg   <= '0;
            pos_reg   <= '0;
            id_reg    <= '0;
            left_reg  <= '0;
            cnt_reg   <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            id_reg    <= id_next;
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vtlv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtlv_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module vtlv_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire vtlv_pkg::result_t push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output vtlv_pkg::result_t      head
);

    vtlv_pkg::result_t                mem_reg [vtlv_pkg::QUEUE_DEPTH];
    logic [vtlv_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [vtlv_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [vtlv_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == vtlv_pkg::QCNT_W'(vtlv_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + vtlv_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + vtlv_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + vtlv_pkg::QCNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - vtlv_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold stored words
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vtlv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vtlv_back
// Output register: presents one result word on the m_ channel.
// ----------------------------------------------------------------------------
module vtlv_back (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 q_valid,
    input  wire vtlv_pkg::result_t                    q_data,
    output logic                                      q_pop,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [vtlv_pkg::KIND_W-1:0]               m_kind,
    output logic [vtlv_pkg::VALUE_W-1:0]              m_value,
    output logic [vtlv_pkg::ERR_W-1:0]                m_error_code,
    output logic [vtlv_pkg::OUT_CNT_W-1:0]            m_byte_total
);

    logic              valid_reg, valid_next;
    vtlv_pkg::result_t data_reg;
    logic              load;

    // Load when empty or when the held word leaves
    assign load       = !valid_reg || m_ready;
    assign q_pop      = load && q_valid;
    assign valid_next = load ? q_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

    assign m_valid      = valid_reg;
    assign m_kind       = data_reg.kind;
    assign m_value      = data_reg.value;
    assign m_error_code = data_reg.error_code;
    assign m_byte_total = data_reg.byte_total;

endmodule

`default_nettype wire

FILE: hw/rtl/varint_tlv_header_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varint_tlv_header_parser_unit
// Parses a header of varint TLV records, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one header byte per word with s_buffer_end marking the
//   last byte available. m_ channel carries result words: chunk sizes, the
//   codec byte, end of header with the byte count, or an error code.
//   A byte gives zero or one result word. The result of an accepted byte
//   passes through the result queue and then the output register before
//   it shows on m_valid. Throughput is one byte per cycle while the queue
//   has room; the parser updates its record state once per byte, and the
//   output register drains one word per cycle while m_ready is high.
//   After an end of header or an error the parser returns to its reset state
//   and the next byte starts a new header.
//   Reset clears the parser, empties the four-entry result queue and drops
//   m_valid. While the receiver stalls, results collect in the queue and the
//   output register; s_ready falls only when the queue is full.
// ----------------------------------------------------------------------------
module varint_tlv_header_parser_unit #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_header_byte,
    input  wire logic                               s_buffer_end,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [vtlv_pkg::KIND_W-1:0]             m_kind,
    output logic [vtlv_pkg::VALUE_W-1:0]            m_value,
    output logic [vtlv_pkg::ERR_W-1:0]              m_error_code,
    output logic [vtlv_pkg::OUT_CNT_W-1:0]          m_byte_total
);

    logic              in_fire;
    logic              res_push;
    vtlv_pkg::result_t res_data;
    logic              q_full;
    logic              q_not_empty;
    vtlv_pkg::result_t q_head;
    logic              q_pop;

    // Accept a word whenever the queue has room
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    vtlv_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_header_byte),
        .in_last  (s_buffer_end),
        .res_push (res_push),
        .res_data (res_data)
    );

    vtlv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    vtlv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_not_empty),
        .q_data       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value      (m_value),
        .m_error_code (m_error_code),
        .m_byte_total (m_byte_total)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the varint TLV header parser. A byte driver feeds
// directed and random headers (well-formed records, broken records, bursts
// of noise, truncations) under random stalls on both channels. A bit-exact
// model of the parser, run on every accepted byte, predicts the result words
// that the monitor compares field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int COUNT_BITS     = 24;
    localparam int DIRECTED_BYTES = 24;
    localparam int RANDOM_BYTES   = 526;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [7:0]  CONT     = 8'h80;
    localparam logic [7:0]  LOW7     = 8'h7F;
    localparam logic [28:0] LEN_MASK = 29'h3FFFFF;

    // Parser phases
    localparam logic [1:0] PH_ID      = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    typedef struct {
        logic [7:0] hbyte;
        logic       last;
        bit         drain;
    } byte_item_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           s_valid       = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_header_byte = 8'h00;
    logic                           s_buffer_end  = 1'b0;
    logic                           m_valid;
    logic                           m_ready       = 1'b0;
    logic [vtlv_pkg::KIND_W-1:0]    m_kind;
    logic [vtlv_pkg::VALUE_W-1:0]   m_value;
    logic [vtlv_pkg::ERR_W-1:0]     m_error_code;
    logic [vtlv_pkg::OUT_CNT_W-1:0] m_byte_total;

    byte_item_t        pending_bytes[$];
    vtlv_pkg::result_t expected_results[$];
    logic [7:0]        hdr_q[$];
    logic [7:0]        pay_q[$];

    int generated    = 0;
    int results_due  = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int cycle_no     = 0;
    int quiet        = 0;
    logic calm;

    // Parser model state
    logic [1:0]            phase_q;
    logic [28:0]           acc;
    logic [1:0]            vpos;
    logic [14:0]           rec_id;
    logic [21:0]           left_cnt;
    logic [COUNT_BITS-1:0] byte_cnt;

    varint_tlv_header_parser_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_header_byte(s_header_byte),
        .s_buffer_end(s_buffer_end),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_value(m_value),
        .m_error_code(m_error_code),
        .m_byte_total(m_byte_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // No stalls on either side inside this window
    assign calm = (cycle_no >= 400) && (cycle_no < 600);

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void restart_parser();
        phase_q  = PH_ID;
        acc      = '0;
        vpos     = '0;
        rec_id   = '0;
        left_cnt = '0;
        byte_cnt = '0;
    endfunction

    function automatic bit parser_error(input logic [vtlv_pkg::ERR_W-1:0] code,
                                        output vtlv_pkg::result_t r);
        restart_parser();
        r            = '0;
        r.kind       = vtlv_pkg::KIND_ERROR;
        r.error_code = code;
        return 1'b1;
    endfunction

    function automatic bit parse_header_byte(input logic [7:0] b, input logic last,
                                             output vtlv_pkg::result_t r);
        logic [21:0]                 left;
        logic                        more;
        logic                        done;
        logic [28:0]                 val;
        logic [vtlv_pkg::KIND_W-1:0] kind;
        logic [21:0]                 len;
        logic [14:0]                 id;
        r = '0;
        if (byte_cnt != '1)
            byte_cnt = byte_cnt + 1'b1;

        // Payload: codec byte or a list of size varints
        if (phase_q == PH_PAYLOAD) begin
            left     = (left_cnt != '0) ? left_cnt - 1'b1 : '0;
            left_cnt = left;
            kind     = vtlv_pkg::KIND_CODEC;
            val      = '0;
            done     = 1'b0;
            if (rec_id == vtlv_pkg::ID_CODEC) begin
                val  = 29'(b);
                done = 1'b1;
            end else begin
                kind = (rec_id == vtlv_pkg::ID_CSIZE) ? vtlv_pkg::KIND_CSIZE
                                                      : vtlv_pkg::KIND_USIZE;
                if (vpos < 2'd3) begin
                    acc  = acc | (29'(b & LOW7) << (7 * int'(vpos)));
                    more = b[7];
                end else begin
                    acc  = acc | (29'(b) << 21);
                    more = 1'b0;
                end
                if (more) begin
                    if (left == '0)
                        return parser_error(vtlv_pkg::ERR_CROSS, r);
                    vpos = vpos + 1'b1;
                end else begin
                    val  = acc;
                    done = 1'b1;
                    acc  = '0;
                    vpos = '0;
                end
            end
            if (left == '0)
                phase_q = PH_ID;
            if (last)
                return parser_error(vtlv_pkg::ERR_TRUNC, r);
            if (done) begin
                r.kind  = kind;
                r.value = val;
                return 1'b1;
            end
            return 1'b0;
        end

        // Payload length
        if (phase_q == PH_LEN) begin
            if (vpos < 2'd2) begin
                acc  = acc | (29'(b & LOW7) << (7 * int'(vpos)));
                more = b[7];
            end else begin
                acc  = acc | (29'(b) << 14);
                more = 1'b0;
            end
            acc = acc & LEN_MASK;
            if (more) begin
                vpos = vpos + 1'b1;
                if (last)
                    return parser_error(vtlv_pkg::ERR_TRUNC, r);
                return 1'b0;
            end
            len  = acc[21:0];
            acc  = '0;
            vpos = '0;
            if (rec_id < vtlv_pkg::ID_CSIZE || rec_id > vtlv_pkg::ID_USIZE)
                return parser_error(vtlv_pkg::ERR_UNKNOWN, r);
            if (rec_id == vtlv_pkg::ID_CODEC && len != 22'd1)
                return parser_error(vtlv_pkg::ERR_METHOD, r);
            if (len == '0) begin
                phase_q = PH_ID;
            end else begin
                phase_q  = PH_PAYLOAD;
                left_cnt = len;
            end
            if (last)
                return parser_error(vtlv_pkg::ERR_TRUNC, r);
            return 1'b0;
        end

        // Record id; the unused phase falls through to here as well
        if (vpos == '0) begin
            if (b[7]) begin
                acc     = 29'(b & LOW7);
                vpos    = 2'd1;
                phase_q = PH_ID;
                if (last)
                    return parser_error(vtlv_pkg::ERR_TRUNC, r);
                return 1'b0;
            end
            id = 15'(b & LOW7);
        end else begin
            id = 15'(acc[6:0]) | (15'(b) << 7);
        end
        acc  = '0;
        vpos = '0;
        if (id == vtlv_pkg::ID_END) begin
            r.kind = vtlv_pkg::KIND_END;
            // Saturate the reported count at the field width
            if (64'(byte_cnt) > 64'({vtlv_pkg::OUT_CNT_W{1'b1}}))
                r.byte_total = '1;
            else
                r.byte_total = vtlv_pkg::OUT_CNT_W'(byte_cnt);
            restart_parser();
            return 1'b1;
        end
        rec_id  = id;
        phase_q = PH_LEN;
        if (last)
            return parser_error(vtlv_pkg::ERR_TRUNC, r);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic put(input logic [7:0] b, input logic last, input bit drain);
        byte_item_t it;
        it.hbyte = b;
        it.last  = last;
        it.drain = drain;
        pending_bytes.push_back(it);
        generated++;
    endtask

    function automatic int unsigned rand_bits(input int max_bits);
        int bits;
        bits = $urandom_range(max_bits, 0);
        if (bits == 0)
            return 0;
        return $urandom & ((32'd1 << bits) - 1);
    endfunction

    // Record id: one byte, or two with the second counting in full
    task automatic add_id(input int unsigned id);
        if (id < 128 && $urandom_range(3, 0) != 0) begin
            hdr_q.push_back(8'(id));
        end else begin
            hdr_q.push_back(CONT | (8'(id) & LOW7));
            hdr_q.push_back(8'(id >> 7));
        end
    endtask

    // Length varint, sometimes in a longer form than needed
    task automatic add_len(input int unsigned len);
        int nb;
        nb = (len < 128) ? 1 : (len < 16384) ? 2 : 3;
        nb = $urandom_range(3, nb);
        for (int i = 0; i < nb - 1; i++)
            hdr_q.push_back(CONT | (8'(len >> (7 * i)) & LOW7));
        if (nb == 3)
            hdr_q.push_back(8'(len >> 14));
        else
            hdr_q.push_back(8'(len >> (7 * (nb - 1))) & LOW7);
    endtask

    // Size varint into the payload buffer
    task automatic add_size(input int unsigned v);
        int nb;
        nb = (v < (1 << 7)) ? 1 : (v < (1 << 14)) ? 2 : (v < (1 << 21)) ? 3 : 4;
        nb = $urandom_range(4, nb);
        for (int i = 0; i < nb - 1; i++)
            pay_q.push_back(CONT | (8'(v >> (7 * i)) & LOW7));
        if (nb == 4)
            pay_q.push_back(8'(v >> 21));
        else
            pay_q.push_back(8'(v >> (7 * (nb - 1))) & LOW7);
    endtask

    task automatic add_payload_record(input int unsigned id);
        add_id(id);
        add_len(pay_q.size());
        foreach (pay_q[i])
            hdr_q.push_back(pay_q[i]);
        pay_q.delete();
    endtask

    task automatic add_size_record(input int unsigned id);
        int k;
        k = $urandom_range(3, 0);
        for (int i = 0; i < k; i++)
            add_size(($urandom_range(9, 0) == 0) ? 32'h1FFFFFFF : rand_bits(29));
        add_payload_record(id);
    endtask

    task automatic add_records(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(2, 0))
                0: add_size_record(vtlv_pkg::ID_CSIZE);
                1: begin
                    add_id(vtlv_pkg::ID_CODEC);
                    add_len(1);
                    hdr_q.push_back(8'($urandom_range(255, 0)));
                end
                default: add_size_record(vtlv_pkg::ID_USIZE);
            endcase
        end
    endtask

    // Push the built header; cut it short now and then, or mark its last byte
    task automatic emit_header(input bit drain);
        int stop;
        int cut_at;
        stop   = hdr_q.size();
        cut_at = -1;
        if ($urandom_range(99, 0) < 15) begin
            cut_at = $urandom_range(stop - 1, 0);
            stop   = cut_at + 1;
        end else if ($urandom_range(99, 0) < 20) begin
            cut_at = stop - 1;
        end
        for (int i = 0; i < stop; i++)
            put(hdr_q[i], i == cut_at, drain && i == 0);
        hdr_q.delete();
    endtask

    // ------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_bytes
        byte_item_t        nxt;
        vtlv_pkg::result_t res;
        logic              nv;
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_header_byte <= 8'h00;
            s_buffer_end  <= 1'b0;
        end else begin
            nv = s_valid;
            // Predict the word accepted at this edge
            if (s_valid && s_ready) begin
                if (parse_header_byte(s_header_byte, s_buffer_end, res)) begin
                    expected_results.push_back(res);
                    results_due++;
                end
                nv = 1'b0;
            end
            // Offer the next word unless idling or holding off for a drain
            if (!nv && pending_bytes.size() != 0 && (calm || $urandom_range(99, 0) >= 34)
                    && !(pending_bytes[0].drain && results_due != results_seen)) begin
                nxt           = pending_bytes.pop_front();
                s_header_byte <= nxt.hbyte;
                s_buffer_end  <= nxt.last;
                nv            = 1'b1;
            end
            s_valid <= nv;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_results
        vtlv_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result word: kind %0d value %0d err %0d count %0d",
                                 m_kind, m_value, m_error_code, m_byte_total);
                end else begin
                    want = expected_results.pop_front();
                    if (m_kind !== want.kind || m_value !== want.value
                            || m_error_code !== want.error_code
                            || m_byte_total !== want.byte_total) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result %0d: expected kind %0d value %0d err %0d count %0d",
                                     results_seen, want.kind, want.value, want.error_code,
                                     want.byte_total);
                            $display("    got kind %0d value %0d err %0d count %0d",
                                     m_kind, m_value, m_error_code, m_byte_total);
                        end
                    end
                end
                results_seen <= results_seen + 1;
            end
            m_ready <= calm || ($urandom_range(99, 0) >= 34);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : run_test
        bit first;
        int n;
        int pick;
        restart_parser();

        // Directed: end marker flagged as the last byte of the buffer
        put(8'h00, 1'b1, 1'b0);
        // Largest compressed size, codec 0xFF, empty uncompressed list, two-byte end
        put(8'h01, 1'b0, 1'b0); put(8'h04, 1'b0, 1'b0);
        put(8'hFF, 1'b0, 1'b0); put(8'hFF, 1'b0, 1'b0);
        put(8'hFF, 1'b0, 1'b0); put(8'hFF, 1'b0, 1'b0);
        put(8'h02, 1'b0, 1'b0); put(8'h01, 1'b0, 1'b0); put(8'hFF, 1'b0, 1'b0);
        put(8'h03, 1'b0, 1'b0); put(8'h00, 1'b0, 1'b0);
        put(8'h80, 1'b0, 1'b0); put(8'h00, 1'b0, 1'b0);
        // Unknown id
        put(8'h04, 1'b0, 1'b0); put(8'h00, 1'b0, 1'b0);
        // Method length other than one
        put(8'h02, 1'b0, 1'b0); put(8'h02, 1'b0, 1'b0);
        // Size varint running past the payload end
        put(8'h01, 1'b0, 1'b0); put(8'h01, 1'b0, 1'b0); put(8'h80, 1'b0, 1'b0);
        // Buffer ends on a size byte
        put(8'h03, 1'b0, 1'b0); put(8'h01, 1'b0, 1'b0); put(8'h05, 1'b1, 1'b0);

        // Random: well-formed headers mixed with broken records and noise
        first = 1'b1;
        while (generated < DIRECTED_BYTES + RANDOM_BYTES) begin
            pick = $urandom_range(99, 0);
            if (pick < 14) begin
                n = $urandom_range(12, 1);
                for (int i = 0; i < n; i++)
                    put(8'($urandom_range(255, 0)),
                        (i == n - 1) || ($urandom_range(99, 0) < 5), 1'b0);
            end else begin
                add_records($urandom_range(3, 0));
                if (pick < 60) begin
                    add_id(vtlv_pkg::ID_END);
                end else if (pick < 72) begin
                    add_id($urandom_range(32767, 4));
                    add_len(rand_bits(22));
                end else if (pick < 84) begin
                    add_id(vtlv_pkg::ID_CODEC);
                    n = rand_bits(22);
                    add_len((n == 1) ? 0 : n);
                end else begin
                    n = $urandom_range(2, 0);
                    for (int i = 0; i < n; i++)
                        add_size(rand_bits(29));
                    n = $urandom_range(3, 1);
                    for (int i = 0; i < n; i++)
                        pay_q.push_back(CONT | 8'($urandom_range(127, 0)));
                    add_payload_record($urandom_range(1, 0) ? vtlv_pkg::ID_CSIZE
                                                            : vtlv_pkg::ID_USIZE);
                end
                emit_header(first || ($urandom_range(99, 0) < 3));
                first = 1'b0;
            end
        end

        // Release reset once the stimulus is built
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the stimulus to drain and every result to come back
        while (pending_bytes.size() != 0 || s_valid || results_seen != results_due)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (expected_results.size() != 0)
            $display("%0d expected result words never arrived", expected_results.size());
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
